// ===== rtl/core/ple_pkg.sv =====
// Shared codes, field widths and the cell control bundle of the positional list engine.
package ple_pkg;

	// Operation codes carried in s_tuser
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;
	localparam logic [2:0] OP_POP    = 3'd5;
	localparam logic [2:0] OP_SEARCH = 3'd6;
	localparam logic [2:0] OP_CLEAR  = 3'd7;

	// Result status codes carried in m_tuser
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Fixed field widths of the stream items
	localparam int OP_BITS    = 3;
	localparam int INDEX_BITS = 7;
	localparam int VALUE_BITS = 32;
	localparam int STAT_BITS  = 2;
	localparam int FOUND_BITS = 6;
	localparam int LEN_BITS   = 7;

	// Width of positions and lengths inside the row; covers the largest list supported
	localparam int POS_BITS = 11;

	// Broadcast from the controller to every cell of the row
	typedef struct packed {
		logic                  shift_up;   // open a gap at pos, load wval there
		logic                  shift_down; // close the gap at pos
		logic                  write_one;  // overwrite the entry at pos
		logic                  read;       // drive the entry at pos onto the read bus
		logic                  search;     // compare live entries against wval
		logic [POS_BITS-1:0]   pos;
		logic [POS_BITS-1:0]   count;
		logic [VALUE_BITS-1:0] wval;
	} ple_ctl_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// One storage cell of the list row: holds one handle and trades it with its neighbors.
module ple_cell import ple_pkg::*; #(
	parameter int HANDLE_BITS = 32
) (
	input  logic                   clk,
	input  ple_ctl_t               ctl,
	input  logic [POS_BITS-1:0]    cell_id,
	input  logic [HANDLE_BITS-1:0] left_entry,
	input  logic [HANDLE_BITS-1:0] right_entry,
	output logic [HANDLE_BITS-1:0] entry,
	output logic                   match,
	output logic [HANDLE_BITS-1:0] rd_data
);

	logic [HANDLE_BITS-1:0]            entry_q;
	logic [HANDLE_BITS-1:0]            entry_d;
	logic [HANDLE_BITS+VALUE_BITS-1:0] wval_ext;
	logic [HANDLE_BITS-1:0]            wval_h;

	// Fit the request handle to the stored width
	assign wval_ext = {{HANDLE_BITS{1'b0}}, ctl.wval};
	assign wval_h   = wval_ext[HANDLE_BITS-1:0];

	// Pick the next content: hold, take a neighbor, or take the new handle
	always_comb begin
		entry_d = entry_q;
		if (ctl.shift_up) begin
			if (cell_id == ctl.pos) begin
				entry_d = wval_h;
			end else if (cell_id > ctl.pos) begin
				entry_d = left_entry;
			end
		end else if (ctl.shift_down) begin
			if (cell_id >= ctl.pos) begin
				entry_d = right_entry;
			end
		end else if (ctl.write_one && (cell_id == ctl.pos)) begin
			entry_d = wval_h;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	// Compare only live entries; place the addressed entry on the read bus
	assign match   = ctl.search && (cell_id < ctl.count) && (entry_q == wval_h);
	assign rd_data = (ctl.read && (cell_id == ctl.pos)) ? entry_q : '0;
	assign entry   = entry_q;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: request decode, cell row and result pipeline.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: op; tdata: index, value
//  m_*       out  m_tvalid/m_tready   tuser: status; tdata: read_value, found_position,
//                                     length, empty_res
//
// A request is taken when the capture stage is free; the row updates at that edge.
// Each request passes the capture stage after the cell row (shift, write, compare),
// then the first-match encode into the result register. A new request is not
// taken until the last one has moved on from the capture stage.
// Reset clears the length and the pipeline valid bits only; cell contents stay as is.
// A stalled result holds the capture stage, which holds s_tready low.
module positional_list_engine import ple_pkg::*; #(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // [2:0] op
	input  logic [39:0] s_tdata,   // [6:0] index, [38:7] value, [39] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic [47:0] m_tdata    // [31:0] read_value, [37:32] found_position,
	                               // [44:38] length, [45] empty_res, [47:46] zero
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int FW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [POS_BITS-1:0] DEPTH_X = POS_BITS'(DEPTH);

	// Request fields
	logic [OP_BITS-1:0]    op;
	logic [INDEX_BITS-1:0] index;
	logic [VALUE_BITS-1:0] value;
	logic                  accept;

	// List length
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [POS_BITS-1:0] cnt_x;
	logic [POS_BITS-1:0] idx_x;

	// Decode results
	ple_ctl_t       ctl;
	logic [1:0]     st_d;
	logic           is_search;

	// Row wiring
	logic [HANDLE_BITS-1:0] ent_w [DEPTH];
	logic [HANDLE_BITS-1:0] rd_w  [DEPTH];
	logic [DEPTH-1:0]       match_w;
	logic [HANDLE_BITS-1:0] rd_or;
	logic [HANDLE_BITS+VALUE_BITS-1:0] rd_ext;

	// Capture stage
	logic                  valid_s1;
	logic [1:0]            st_s1;
	logic [VALUE_BITS-1:0] rd_s1;
	logic                  search_s1;
	logic [DEPTH-1:0]      match_s1;
	logic                  advance;

	// Result register
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [VALUE_BITS-1:0] read_q;
	logic [FOUND_BITS-1:0] found_q;
	logic [LEN_BITS-1:0]   length_q;
	logic                  empty_q;

	// First-match encode
	logic [FW-1:0]            found_idx;
	logic                     hit;
	logic [FW+FOUND_BITS-1:0] found_ext;
	logic [CW+LEN_BITS-1:0]   len_ext;

	assign op     = s_tuser;
	assign index  = s_tdata[INDEX_BITS-1:0];
	assign value  = s_tdata[INDEX_BITS+VALUE_BITS-1:INDEX_BITS];
	assign accept = s_tvalid && s_tready;

	assign s_tready = !valid_s1;
	assign advance  = valid_s1 && (!out_valid_q || m_tready);

	assign cnt_x = POS_BITS'(count_q);
	assign idx_x = {{(POS_BITS - INDEX_BITS){1'b0}}, index};

	// Decode the request into row commands, status and the next length
	always_comb begin
		ctl            = '0;
		ctl.count      = cnt_x;
		ctl.wval       = value;
		ctl.pos        = idx_x;
		st_d           = ST_OK;
		count_d        = count_q;
		is_search      = 1'b0;
		case (op)
			OP_APPEND: begin
				if (cnt_x == DEPTH_X) begin
					st_d = ST_FULL;
				end else begin
					ctl.write_one = accept;
					ctl.pos       = cnt_x;
					count_d       = count_q + CW'(1);
				end
			end
			OP_INSERT: begin
				if (idx_x > cnt_x) begin
					st_d = ST_RANGE;
				end else if (cnt_x == DEPTH_X) begin
					st_d = ST_FULL;
				end else begin
					ctl.shift_up = accept;
					count_d      = count_q + CW'(1);
				end
			end
			OP_GET, OP_SET, OP_REMOVE, OP_POP: begin
				if (idx_x >= cnt_x) begin
					st_d = ST_RANGE;
				end else begin
					ctl.write_one  = accept && (op == OP_SET);
					ctl.read       = accept && ((op == OP_GET) || (op == OP_POP));
					ctl.shift_down = accept && ((op == OP_REMOVE) || (op == OP_POP));
					if ((op == OP_REMOVE) || (op == OP_POP)) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			OP_SEARCH: begin
				ctl.search = accept;
				is_search  = 1'b1;
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	// Row of cells, each tied to its neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [HANDLE_BITS-1:0] left_in;
		logic [HANDLE_BITS-1:0] right_in;
		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = ent_w[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = ent_w[g+1];
		end
		ple_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cell_id    (POS_BITS'(g)),
			.left_entry (left_in),
			.right_entry(right_in),
			.entry      (ent_w[g]),
			.match      (match_w[g]),
			.rd_data    (rd_w[g])
		);
	end

	// Gather the one addressed entry from the read bus
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | rd_w[i];
		end
	end
	assign rd_ext = {{VALUE_BITS{1'b0}}, rd_or};

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Capture stage: hold the request's outcome until the result register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1     <= st_d;
			rd_s1     <= rd_ext[VALUE_BITS-1:0];
			search_s1 <= is_search;
			match_s1  <= match_w;
		end
	end

	// Lowest matching position
	always_comb begin
		found_idx = '0;
		hit       = 1'b0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				found_idx = FW'(i);
				hit       = 1'b1;
			end
		end
	end
	assign found_ext = {{FOUND_BITS{1'b0}}, found_idx};
	assign len_ext   = {{LEN_BITS{1'b0}}, count_q};

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= (search_s1 && !hit) ? ST_NOT_FOUND : st_s1;
			read_q   <= rd_s1;
			found_q  <= found_ext[FOUND_BITS-1:0];
			length_q <= len_ext[LEN_BITS-1:0];
			empty_q  <= (count_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, empty_q, length_q, found_q, read_q};

	// Length never passes the row size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		POS_BITS'(count_q) <= DEPTH_X)
		else $error("list length beyond row size");

	// A taken request always lands in the capture stage
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request not captured");

	// Clear empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_CLEAR)) |=> (count_q == '0))
		else $error("clear left entries");

	// Append with room grows the list by one
	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_APPEND) && (cnt_x != DEPTH_X))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not grow the list");

	// Empty flag agrees with the reported length when the length fits the field
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (length_q != '0)) |-> !empty_q)
		else $error("empty flag set with entries present");

endmodule
